// File: rtl/opit_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and widths of the ordered permit issue table
// no dependencies

package opit_pkg;

    localparam int C_SLOTS = 8;

    localparam int C_CMD_W  = 3;
    localparam int C_KEY_W  = 64;
    localparam int C_LEN_W  = 32;
    localparam int C_WORD_W = 64;
    localparam int C_DIG_W  = 4 * C_WORD_W;
    localparam int C_RES_W  = 3;
    localparam int C_ST_W   = 3;
    localparam int C_CNT_W  = 4;

    // commands
    localparam logic [C_CMD_W-1:0] CMD_ADMIT     = 3'd0;
    localparam logic [C_CMD_W-1:0] CMD_BEGIN     = 3'd1;
    localparam logic [C_CMD_W-1:0] CMD_HOLD      = 3'd2;
    localparam logic [C_CMD_W-1:0] CMD_COMPLETE  = 3'd3;
    localparam logic [C_CMD_W-1:0] CMD_COMP_ALL  = 3'd4;
    localparam logic [C_CMD_W-1:0] CMD_QUERY     = 3'd5;

    // result codes
    localparam logic [C_RES_W-1:0] RS_OK           = 3'd0;
    localparam logic [C_RES_W-1:0] RS_QUEUED       = 3'd1;
    localparam logic [C_RES_W-1:0] RS_INVALID      = 3'd2;
    localparam logic [C_RES_W-1:0] RS_DUPLICATE    = 3'd3;
    localparam logic [C_RES_W-1:0] RS_CAPACITY     = 3'd4;
    localparam logic [C_RES_W-1:0] RS_NOT_FOUND    = 3'd5;
    localparam logic [C_RES_W-1:0] RS_OUT_OF_ORDER = 3'd6;

    // slot states
    localparam logic [C_ST_W-1:0] ST_EMPTY  = 3'd0;
    localparam logic [C_ST_W-1:0] ST_QUEUED = 3'd1;
    localparam logic [C_ST_W-1:0] ST_HEAD   = 3'd2;
    localparam logic [C_ST_W-1:0] ST_IN_TX  = 3'd3;
    localparam logic [C_ST_W-1:0] ST_HELD   = 3'd4;

    typedef struct packed {
        logic [C_CMD_W-1:0]  cmd;
        logic [C_KEY_W-1:0]  authority;
        logic [C_KEY_W-1:0]  sequence_req;
        logic [C_LEN_W-1:0]  body_length;
        logic [C_WORD_W-1:0] digest_word0;
        logic [C_WORD_W-1:0] digest_word1;
        logic [C_WORD_W-1:0] digest_word2;
        logic [C_WORD_W-1:0] digest_word3;
    } t_req;

    typedef struct packed {
        logic [C_RES_W-1:0] status;
        logic [C_KEY_W-1:0] head_sequence;
        logic [C_ST_W-1:0]  entry_state;
        logic [C_CNT_W-1:0] entry_count;
        logic               digest_match;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic cmp;
        logic apply;
        logic scan;
        logic fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/opit_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces
// depends on opit_pkg

interface opit_req_if
    import opit_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [C_CMD_W-1:0]  cmd;
    logic [C_KEY_W-1:0]  authority;
    logic [C_KEY_W-1:0]  sequence_req;
    logic [C_LEN_W-1:0]  body_length;
    logic [C_WORD_W-1:0] digest_word0;
    logic [C_WORD_W-1:0] digest_word1;
    logic [C_WORD_W-1:0] digest_word2;
    logic [C_WORD_W-1:0] digest_word3;

    modport source (output valid, cmd, authority, sequence_req, body_length,
                    digest_word0, digest_word1, digest_word2, digest_word3,
                    input ready);
    modport sink (input valid, cmd, authority, sequence_req, body_length,
                  digest_word0, digest_word1, digest_word2, digest_word3,
                  output ready);
endinterface

interface opit_rsp_if
    import opit_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [C_RES_W-1:0] status;
    logic [C_KEY_W-1:0] head_sequence;
    logic [C_ST_W-1:0]  entry_state;
    logic [C_CNT_W-1:0] entry_count;
    logic               digest_match;

    modport source (output valid, status, head_sequence, entry_state, entry_count,
                    digest_match, input ready);
    modport sink (input valid, status, head_sequence, entry_state, entry_count,
                  digest_match, output ready);
endinterface

// File: rtl/ordered_permit_issue_table_top.sv
`timescale 1ns / 1ps
// top level of the ordered permit issue table
// depends on opit_pkg, opit_if, opit_ctrl, opit_dp
//
//  channel  | dir | handshake     | payload
//  i_req    | in  | valid / ready | cmd, authority, sequence_req, length, digest
//  o_rsp    | out | valid / ready | status, head, entry state, count, match
//
// each request runs through latch, compare lanes, update,
// a head and live-count scan of one slot per cycle, then result load
// reset empties every slot; slot keys, lengths and digests are not cleared
// a stalled response holds the controller in the final step until the result
// register drains; the next request can be taken while a result waits
// requests are taken one at a time

module ordered_permit_issue_table_top
    import opit_pkg::*;
#(
    parameter int SLOTS = C_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    opit_req_if.sink    i_req,
    opit_rsp_if.source  o_rsp
);
    t_cmd w_cmd;
    t_sts w_sts;
    t_req w_req;
    t_rsp w_rsp;

    // gather the request fields
    assign w_req.cmd          = i_req.cmd;
    assign w_req.authority    = i_req.authority;
    assign w_req.sequence_req = i_req.sequence_req;
    assign w_req.body_length  = i_req.body_length;
    assign w_req.digest_word0 = i_req.digest_word0;
    assign w_req.digest_word1 = i_req.digest_word1;
    assign w_req.digest_word2 = i_req.digest_word2;
    assign w_req.digest_word3 = i_req.digest_word3;

    opit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    opit_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (w_rsp)
    );

    // spread the result fields
    assign o_rsp.status        = w_rsp.status;
    assign o_rsp.head_sequence = w_rsp.head_sequence;
    assign o_rsp.entry_state   = w_rsp.entry_state;
    assign o_rsp.entry_count   = w_rsp.entry_count;
    assign o_rsp.digest_match  = w_rsp.digest_match;
endmodule

// File: rtl/opit_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the permit table
// depends on opit_pkg

module opit_ctrl
    import opit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_FIN;
            end
            S_FIN: begin
                // wait for the output register to drain
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

// File: rtl/opit_dp.sv
`timescale 1ns / 1ps
// slot storage, per-slot compare lanes, head scan and result register
// depends on opit_pkg

module opit_dp
    import opit_pkg::*;
#(
    parameter int SLOTS = C_SLOTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [C_ST_W-1:0]  r_st   [SLOTS];
    logic [C_KEY_W-1:0] r_auth [SLOTS];
    logic [C_KEY_W-1:0] r_seq  [SLOTS];
    logic [C_LEN_W-1:0] r_len  [SLOTS];
    logic [C_DIG_W-1:0] r_dig  [SLOTS];

    t_req r_q;
    logic [SLOTS-1:0] r_key_hit, r_auth_hit, r_ld;
    logic [SLOTS-1:0] w_live, w_key, w_ah, w_ld;
    logic [IW-1:0]    r_fe_idx, w_fe_idx, w_key_idx;
    logic             r_fe_any, w_fe_any;
    logic [C_ST_W-1:0] w_kst;
    logic [C_DIG_W-1:0] w_qdig;

    logic [C_RES_W-1:0] r_res;
    logic [C_ST_W-1:0]  r_est;
    logic               r_mt, r_admitted, r_remark;

    logic [IW-1:0]      r_idx;
    logic [C_KEY_W-1:0] r_best;
    logic               r_any;
    logic [CW-1:0]      r_cnt;
    logic [C_KEY_W-1:0] w_head;

    logic               r_out_valid;
    t_rsp               r_out;

    logic w_key_any, w_dup, w_adm_valid, w_adm_ok;

    assign w_qdig = {r_q.digest_word3, r_q.digest_word2, r_q.digest_word1, r_q.digest_word0};

    // compare lanes, one per slot
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_live[i] = (r_st[i] != ST_EMPTY);
            w_ah[i]   = w_live[i] && (r_auth[i] == r_q.authority);
            w_key[i]  = w_ah[i] && (r_seq[i] == r_q.sequence_req);
            w_ld[i]   = (r_len[i] == r_q.body_length) && (r_dig[i] == w_qdig);
        end
    end

    // lowest empty slot and index of the addressed key
    always_comb begin
        w_fe_any  = 1'b0;
        w_fe_idx  = '0;
        w_key_idx = '0;
        w_kst     = ST_EMPTY;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!w_live[i]) begin
                w_fe_any = 1'b1;
                w_fe_idx = IW'(i);
            end
            if (r_key_hit[i]) w_key_idx = IW'(i);
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (r_key_hit[i]) w_kst = w_kst | r_st[i];
        end
    end

    assign w_key_any   = |r_key_hit;
    assign w_dup       = |(r_auth_hit & r_ld);
    assign w_adm_valid = (r_q.authority != '0) && (r_q.sequence_req != '0)
                         && (r_q.body_length != '0);
    assign w_adm_ok    = (r_q.cmd == CMD_ADMIT) && w_adm_valid && !w_key_any && !w_dup
                         && r_fe_any;
    assign w_head      = r_any ? r_best : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_q <= i_req;
        if (i_cmd.cmp) begin
            r_key_hit  <= w_key;
            r_auth_hit <= w_ah;
            r_ld       <= w_ld;
            r_fe_idx   <= w_fe_idx;
            r_fe_any   <= w_fe_any;
        end
        if (i_cmd.apply && w_adm_ok) begin
            r_auth[r_fe_idx]     <= r_q.authority;
            r_seq[r_fe_idx]      <= r_q.sequence_req;
            r_len[r_fe_idx]      <= r_q.body_length;
            r_dig[r_fe_idx]      <= w_qdig;
            r_auth_hit[r_fe_idx] <= 1'b1;
            r_key_hit[r_fe_idx]  <= 1'b1;
        end
    end

    // decision, state changes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) r_st[i] <= ST_EMPTY;
            r_admitted <= 1'b0;
            r_remark   <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_admitted <= 1'b0;
                r_remark   <= 1'b0;
                r_est      <= ST_EMPTY;
                r_mt       <= 1'b0;
                r_res      <= RS_INVALID;
                unique case (r_q.cmd)
                    CMD_ADMIT: begin
                        if (!w_adm_valid)    r_res <= RS_INVALID;
                        else if (w_key_any)  r_res <= RS_DUPLICATE;
                        else if (w_dup)      r_res <= RS_DUPLICATE;
                        else if (!r_fe_any)  r_res <= RS_CAPACITY;
                        else begin
                            r_st[r_fe_idx] <= ST_QUEUED;
                            r_admitted     <= 1'b1;
                            r_remark       <= 1'b1;
                        end
                    end
                    CMD_BEGIN: begin
                        if (!w_key_any) r_res <= RS_NOT_FOUND;
                    end
                    CMD_HOLD: begin
                        if (!w_key_any) r_res <= RS_NOT_FOUND;
                        else if (w_kst != ST_IN_TX && w_kst != ST_HEAD) r_res <= RS_INVALID;
                        else begin
                            r_st[w_key_idx] <= ST_HELD;
                            r_res           <= RS_OK;
                        end
                    end
                    CMD_COMPLETE: begin
                        if (!w_key_any) r_res <= RS_NOT_FOUND;
                        else begin
                            r_st[w_key_idx] <= ST_EMPTY;
                            r_remark        <= 1'b1;
                            r_res           <= RS_OK;
                        end
                    end
                    CMD_COMP_ALL: begin
                        if (r_q.authority != '0) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (r_auth_hit[i]) r_st[i] <= ST_EMPTY;
                            end
                        end
                        r_res <= RS_OK;
                    end
                    CMD_QUERY: begin
                        if (!w_key_any) r_res <= RS_NOT_FOUND;
                        else begin
                            r_res <= RS_OK;
                            r_est <= w_kst;
                            r_mt  <= |(r_key_hit & r_ld);
                        end
                    end
                    default: r_res <= RS_INVALID;
                endcase
            end
            if (i_cmd.fin) begin
                if (r_remark) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (w_live[i] && r_auth_hit[i]
                            && (r_st[i] == ST_QUEUED || r_st[i] == ST_HEAD)) begin
                            r_st[i] <= (r_any && r_seq[i] == r_best) ? ST_HEAD : ST_QUEUED;
                        end
                    end
                end
                if (r_q.cmd == CMD_BEGIN && w_key_any
                    && (w_kst == ST_HEAD || w_kst == ST_HELD)
                    && w_head == r_q.sequence_req) begin
                    r_st[w_key_idx] <= ST_IN_TX;
                end
            end
        end
    end

    // head scan and live count, one slot a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_idx  <= '0;
            r_any  <= 1'b0;
            r_best <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            if (w_live[r_idx]) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_auth_hit[r_idx] && r_seq[r_idx] != '0
                    && (!r_any || r_seq[r_idx] < r_best)) begin
                    r_best <= r_seq[r_idx];
                    r_any  <= 1'b1;
                end
            end
        end
    end

    assign o_sts.scan_last = (r_idx == IW'(SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_rsp_ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.fin) begin
            r_out.head_sequence <= w_head;
            r_out.entry_state   <= r_est;
            r_out.entry_count   <= C_CNT_W'(r_cnt);
            r_out.digest_match  <= r_mt;
            if (r_admitted) begin
                r_out.status <= (w_head == r_q.sequence_req) ? RS_OK : RS_QUEUED;
            end else if (r_q.cmd == CMD_BEGIN && w_key_any) begin
                r_out.status <= ((w_kst == ST_HEAD || w_kst == ST_HELD)
                                 && w_head == r_q.sequence_req) ? RS_OK : RS_OUT_OF_ORDER;
            end else begin
                r_out.status <= r_res;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_key_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> $onehot0(r_key_hit)) else $error("key matches more than one slot");
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |=> r_out_valid) else $error("result not loaded");
    a_head_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (r_any == (r_best != '0))) else $error("head scan inconsistent");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (r_cnt <= CW'(SLOTS))) else $error("live count overflow");
endmodule
